FILE: src/citt_pkg.sv
// Shared types, opcodes and helpers for the connection idle-timeout table.
package citt_pkg;

	localparam logic [2:0] OP_REQ_START    = 3'd0;
	localparam logic [2:0] OP_REQ_COMPLETE = 3'd1;
	localparam logic [2:0] OP_CLOSE        = 3'd2;
	localparam logic [2:0] OP_QUERY        = 3'd3;
	localparam logic [2:0] OP_TICK         = 3'd4;
	localparam logic [2:0] OP_SWEEP        = 3'd5;
	localparam logic [2:0] OP_RESET_STATS  = 3'd6;

	localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd60;

	typedef struct packed {
		logic        keep;
		logic [31:0] requests;
		logic [31:0] stamp;
		logic [15:0] timeout;
	} entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

FILE: src/citt_age.sv
// Shared age unit: idle seconds of an entry and its expiry compare.
module citt_age (
	input  logic [31:0]      now,
	input  citt_pkg::entry_t entry,
	output logic [31:0]      idle,
	output logic             expired
);
	import citt_pkg::*;

	assign idle    = now - entry.stamp;
	assign expired = entry.keep && (idle >= {16'd0, entry.timeout});

endmodule

FILE: src/connection_idle_timeout_table.sv
// Connection idle-timeout table: one word in, one or more report words out.
// A table of SLOTS connection entries kept in a single-port RAM with valid bits in
// flops. One small sequencer drives a shared age unit (subtract and compare). A
// non-sweep word goes through the accept, RAM read, update and report steps before its
// report word is loaded into the output register. A sweep walks the table with a RAM
// read and a check per slot: a counting pass, then, if any entry expired, an evicting
// pass that stops after the last eviction and emits one word per eviction. A sweep
// that finds nothing expired emits one word with no entry after the counting pass.
// Output stalls can hold both kinds of word.
// in_ready is high only while the sequencer is idle; a report word waits in the
// output register without blocking the next accept.
module connection_idle_timeout_table #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [5:0]  conn,
	input  logic        keep_req,
	input  logic [15:0] req_timeout,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  slot,
	output logic        found,
	output logic        entry_keep_alive,
	output logic [31:0] entry_requests,
	output logic [31:0] idle_seconds,
	output logic        timed_out,
	output logic        evicted,
	output logic [31:0] total_requests,
	output logic [31:0] total_timeouts,
	output logic [6:0]  active_count,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import citt_pkg::*;

	localparam int IW = $clog2(SLOTS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_UPD   = 3'd2;
	localparam logic [2:0] S_REP   = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_EMPTY = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       op_q;
	logic [5:0]       conn_q;
	logic             ka_q;
	logic [15:0]      to_q;
	logic             inrange_q;
	logic             found_q;
	logic             show_q;
	logic             pass_q;
	logic [6:0]       cnt_q;
	logic [6:0]       rem_q;
	logic [IW-1:0]    addr_q;
	logic [SLOTS-1:0] valid_q;
	logic [31:0]      now_q;
	logic [31:0]      req_tot_q;
	logic [31:0]      to_tot_q;
	logic [6:0]       live_q;
	logic [15:0]      dflt_q;
	entry_t           entry_q;
	entry_t           rd_q;
	entry_t           mem [SLOTS];

	logic             out_valid_q;
	logic [5:0]       slot_q;
	logic             found_out_q;
	logic             keep_out_q;
	logic [31:0]      req_out_q;
	logic [31:0]      idle_out_q;
	logic             timed_out_q;
	logic             evicted_q;
	logic [31:0]      tot_req_out_q;
	logic [31:0]      tot_to_out_q;
	logic [6:0]       active_out_q;
	logic             last_q;

	logic             accept;
	logic             in_rng;
	logic [IW-1:0]    idx_in;
	logic             addr_last;
	logic             out_free;
	logic             out_load;
	logic             mem_we;
	logic             show;
	logic             hit;
	logic             shown;
	entry_t           e_new;
	entry_t           age_entry;
	logic [31:0]      age_idle;
	logic             age_exp;
	logic [32:0]      to_sum;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_rng    = ({1'b0, conn} < 7'(SLOTS));
	assign idx_in    = conn[IW-1:0];
	assign addr_last = (addr_q == IW'(SLOTS - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free &&
		((state_q == S_REP) || (state_q == S_EMIT) || (state_q == S_EMPTY));
	assign show      = found_q || ((op_q == OP_REQ_START) && inrange_q);
	assign mem_we    = (state_q == S_UPD) &&
		(((op_q == OP_REQ_START) && inrange_q) || ((op_q == OP_REQ_COMPLETE) && found_q));
	assign to_sum    = {1'b0, to_tot_q} + {26'd0, cnt_q};

	assign age_entry = (state_q == S_CHK) ? rd_q : entry_q;

	citt_age u_age (
		.now     (now_q),
		.entry   (age_entry),
		.idle    (age_idle),
		.expired (age_exp)
	);

	assign hit = valid_q[addr_q] && age_exp;

	always_comb begin
		e_new = rd_q;
		case (op_q)
			OP_REQ_START: begin
				if (!found_q) begin
					e_new.requests = 32'd1;
					e_new.timeout  = (to_q != 16'd0) ? to_q : dflt_q;
				end else begin
					e_new.requests = sat_inc(rd_q.requests);
					if (to_q != 16'd0) e_new.timeout = to_q;
				end
				e_new.stamp = now_q;
				e_new.keep  = ka_q;
			end
			OP_REQ_COMPLETE: e_new.stamp = now_q;
			default: ;
		endcase
	end

	// entry RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_q] <= e_new;
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			conn_q    <= conn;
			ka_q      <= keep_req;
			to_q      <= req_timeout;
			inrange_q <= in_rng;
			found_q   <= in_rng && valid_q[idx_in];
			addr_q    <= (opcode == OP_SWEEP) ? '0 : idx_in;
		end
		case (state_q)
			S_UPD: begin
				entry_q <= e_new;
				show_q  <= show;
			end
			S_CHK: begin
				if (pass_q && hit) entry_q <= rd_q;
				else if (!addr_last) addr_q <= addr_q + 1'b1;
			end
			S_FIN: addr_q <= '0;
			S_EMIT: if (out_free) addr_q <= addr_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			now_q       <= '0;
			req_tot_q   <= '0;
			to_tot_q    <= '0;
			live_q      <= '0;
			dflt_q      <= DEFAULT_TIMEOUT_RST;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) dflt_q <= cfg_wdata;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
						pass_q  <= 1'b0;
						cnt_q   <= '0;
					end
				end
				S_RD: state_q <= (op_q == OP_SWEEP) ? S_CHK : S_UPD;
				S_UPD: begin
					case (op_q)
						OP_REQ_START: begin
							if (inrange_q) begin
								if (!found_q) begin
									valid_q[addr_q] <= 1'b1;
									live_q          <= live_q + 7'd1;
								end
								req_tot_q <= sat_inc(req_tot_q);
							end
						end
						OP_CLOSE: begin
							if (found_q) begin
								valid_q[addr_q] <= 1'b0;
								live_q          <= live_q - 7'd1;
							end
						end
						OP_TICK: now_q <= sat_inc(now_q);
						OP_RESET_STATS: begin
							req_tot_q <= '0;
							to_tot_q  <= '0;
						end
						default: ;
					endcase
					state_q <= S_REP;
				end
				S_REP: if (out_free) state_q <= S_IDLE;
				S_CHK: begin
					if (!pass_q) begin
						if (hit) cnt_q <= cnt_q + 7'd1;
						state_q <= addr_last ? S_FIN : S_RD;
					end else if (hit) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= addr_last ? S_IDLE : S_RD;
					end
				end
				S_FIN: begin
					pass_q   <= 1'b1;
					rem_q    <= cnt_q;
					to_tot_q <= to_sum[32] ? 32'hFFFF_FFFF : to_sum[31:0];
					live_q   <= live_q - cnt_q;
					state_q  <= (cnt_q == 7'd0) ? S_EMPTY : S_RD;
				end
				S_EMIT: begin
					if (out_free) begin
						valid_q[addr_q] <= 1'b0;
						rem_q           <= rem_q - 7'd1;
						state_q         <= (rem_q == 7'd1) ? S_IDLE : S_RD;
					end
				end
				S_EMPTY: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// report word register
	assign shown = (state_q == S_REP) ? show_q : (state_q == S_EMIT);

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q        <= (state_q == S_REP) ? conn_q :
			                 (state_q == S_EMIT) ? 6'(addr_q) : 6'd0;
			found_out_q   <= (state_q == S_REP) ? found_q : (state_q == S_EMIT);
			keep_out_q    <= shown && entry_q.keep;
			req_out_q     <= shown ? entry_q.requests : 32'd0;
			idle_out_q    <= shown ? age_idle : 32'd0;
			timed_out_q   <= shown && age_exp;
			evicted_q     <= (state_q == S_EMIT);
			tot_req_out_q <= req_tot_q;
			tot_to_out_q  <= to_tot_q;
			active_out_q  <= live_q;
			last_q        <= (state_q != S_EMIT) || (rem_q == 7'd1);
		end
	end

	assign out_valid        = out_valid_q;
	assign slot             = slot_q;
	assign found            = found_out_q;
	assign entry_keep_alive = keep_out_q;
	assign entry_requests   = req_out_q;
	assign idle_seconds     = idle_out_q;
	assign timed_out        = timed_out_q;
	assign evicted          = evicted_q;
	assign total_requests   = tot_req_out_q;
	assign total_timeouts   = tot_to_out_q;
	assign active_count     = active_out_q;
	assign last             = last_q;

	a_live_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(valid_q) == int'(live_q)))
		else $error("live count disagrees with valid bits");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= 7'(SLOTS))
		else $error("live count beyond table size");

	a_evict_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> (found_out_q && timed_out_q))
		else $error("eviction word without an expired entry");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready while a word is in progress");

endmodule

FILE: tb/connection_idle_timeout_table_checker.sv
`timescale 1ns / 100ps
// Checker for the connection idle-timeout table: shadow table, expected report words, compare.
module connection_idle_timeout_table_checker #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [5:0]  conn,
	input  logic        keep_req,
	input  logic [15:0] req_timeout,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  slot,
	input  logic        found,
	input  logic        entry_keep_alive,
	input  logic [31:0] entry_requests,
	input  logic [31:0] idle_seconds,
	input  logic        timed_out,
	input  logic        evicted,
	input  logic [31:0] total_requests,
	input  logic [31:0] total_timeouts,
	input  logic [6:0]  active_count,
	input  logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);
	import citt_pkg::*;

	typedef struct packed {
		logic [5:0]  slot;
		logic        found;
		logic        keep;
		logic [31:0] requests;
		logic [31:0] idle;
		logic        timed_out;
		logic        evicted;
		logic [31:0] total_requests;
		logic [31:0] total_timeouts;
		logic [6:0]  active;
		logic        last;
	} report_t;

	logic        live [SLOTS];
	logic        keep_flag [SLOTS];
	logic [31:0] req_count [SLOTS];
	logic [31:0] last_seen [SLOTS];
	logic [15:0] idle_limit [SLOTS];
	logic [31:0] now_sec;
	logic [31:0] starts_total;
	logic [31:0] evictions_total;
	logic [6:0]  live_total;
	logic [15:0] default_timeout;
	report_t     expected_reports [$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic report_t entry_report(input int s, input logic show);
		report_t r;
		logic [31:0] idle;
		r = '0;
		r.slot = s[5:0];
		if (show) begin
			idle = now_sec - last_seen[s];
			r.keep = keep_flag[s];
			r.requests = req_count[s];
			r.idle = idle;
			r.timed_out = keep_flag[s] && (idle >= {16'd0, idle_limit[s]});
		end
		return r;
	endfunction

	function automatic string describe(input report_t r);
		return $sformatf({"slot %0d found %0b keep %0b req %0d idle %0d timed_out %0b ",
			"evicted %0b total_req %0d total_to %0d active %0d last %0b"},
			r.slot, r.found, r.keep, r.requests, r.idle, r.timed_out, r.evicted,
			r.total_requests, r.total_timeouts, r.active, r.last);
	endfunction

	task automatic apply_word(input logic [2:0] op, input logic [5:0] c, input logic ka,
			input logic [15:0] to);
		report_t r;
		report_t batch [$];
		logic hit;
		hit = live[c];
		if (op == OP_SWEEP) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i]) begin
					r = entry_report(i, 1'b1);
					if (r.timed_out) begin
						r.found = 1'b1;
						r.evicted = 1'b1;
						batch.insert(batch.size(), r);
						live[i] = 1'b0;
						live_total = live_total - 7'd1;
						evictions_total = bump(evictions_total);
					end
				end
			end
			if (batch.size() == 0) begin
				r = '0;
				batch.insert(batch.size(), r);
			end
		end else begin
			// close reports the entry as it was before removal
			r = entry_report(c, hit);
			case (op)
				OP_REQ_START: begin
					if (!hit) begin
						live[c] = 1'b1;
						req_count[c] = 32'd1;
						idle_limit[c] = (to != 16'd0) ? to : default_timeout;
						live_total = live_total + 7'd1;
					end else begin
						req_count[c] = bump(req_count[c]);
						if (to != 16'd0)
							idle_limit[c] = to;
					end
					last_seen[c] = now_sec;
					keep_flag[c] = ka;
					starts_total = bump(starts_total);
				end
				OP_REQ_COMPLETE: begin
					if (hit)
						last_seen[c] = now_sec;
				end
				OP_CLOSE: begin
					if (hit) begin
						live[c] = 1'b0;
						live_total = live_total - 7'd1;
					end
				end
				OP_TICK: now_sec = bump(now_sec);
				OP_RESET_STATS: begin
					starts_total = 32'd0;
					evictions_total = 32'd0;
				end
				default: ;
			endcase
			if (op != OP_CLOSE)
				r = entry_report(c, live[c]);
			r.found = hit;
			batch.insert(batch.size(), r);
		end
		for (int k = 0; k < batch.size(); k++) begin
			r = batch[k];
			r.total_requests = starts_total;
			r.total_timeouts = evictions_total;
			r.active = live_total;
			r.last = (k == batch.size() - 1);
			expected_reports.insert(expected_reports.size(), r);
		end
	endtask

	task automatic check_report();
		report_t got;
		report_t want;
		got.slot = slot;
		got.found = found;
		got.keep = entry_keep_alive;
		got.requests = entry_requests;
		got.idle = idle_seconds;
		got.timed_out = timed_out;
		got.evicted = evicted;
		got.total_requests = total_requests;
		got.total_timeouts = total_timeouts;
		got.active = active_count;
		got.last = last;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: %s", describe(got));
		end else begin
			want = expected_reports.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				live[i] = 1'b0;
			now_sec = '0;
			starts_total = '0;
			evictions_total = '0;
			live_total = '0;
			default_timeout = DEFAULT_TIMEOUT_RST;
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				default_timeout = cfg_wdata;
			if (in_valid && in_ready)
				apply_word(opcode, conn, keep_req, req_timeout);
			if (out_valid && out_ready)
				check_report();
			pending <= expected_reports.size();
		end
	end

endmodule

FILE: tb/connection_idle_timeout_table_test.sv
`timescale 1ns / 100ps
// Testbench top for the connection idle-timeout table: stimulus, flow control and verdict.
module connection_idle_timeout_table_test;
	import citt_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = OP_QUERY;
	logic [5:0]  conn = '0;
	logic        keep_req = 1'b0;
	logic [15:0] req_timeout = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  slot;
	logic        found;
	logic        entry_keep_alive;
	logic [31:0] entry_requests;
	logic [31:0] idle_seconds;
	logic        timed_out;
	logic        evicted;
	logic [31:0] total_requests;
	logic [31:0] total_timeouts;
	logic [6:0]  active_count;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          fail_count;
	int          pending;
	bit          idling = 1'b1;
	int          ready_left = 0;

	connection_idle_timeout_table #(.SLOTS(64)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .conn(conn), .keep_req(keep_req), .req_timeout(req_timeout),
		.out_valid(out_valid), .out_ready(out_ready),
		.slot(slot), .found(found), .entry_keep_alive(entry_keep_alive),
		.entry_requests(entry_requests), .idle_seconds(idle_seconds), .timed_out(timed_out),
		.evicted(evicted), .total_requests(total_requests), .total_timeouts(total_timeouts),
		.active_count(active_count), .last(last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	connection_idle_timeout_table_checker #(.SLOTS(64)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .conn(conn), .keep_req(keep_req), .req_timeout(req_timeout),
		.out_valid(out_valid), .out_ready(out_ready),
		.slot(slot), .found(found), .entry_keep_alive(entry_keep_alive),
		.entry_requests(entry_requests), .idle_seconds(idle_seconds), .timed_out(timed_out),
		.evicted(evicted), .total_requests(total_requests), .total_timeouts(total_timeouts),
		.active_count(active_count), .last(last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver: random stall bursts and long ready stretches while idling is set, else always ready
	always @(posedge clk) begin
		if (!idling) begin
			out_ready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left = ready_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			ready_left = $urandom_range(1, 18) - 1;
		end else begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(0, 40);
		end
	end

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input logic [2:0] op, input logic [5:0] c, input logic ka,
			input logic [15:0] to);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		conn <= c;
		keep_req <= ka;
		req_timeout <= to;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_word();
		int pick;
		logic [2:0] op;
		logic [5:0] c;
		logic [15:0] to;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = OP_REQ_START;
		else if (pick < 40)
			op = OP_REQ_COMPLETE;
		else if (pick < 46)
			op = OP_CLOSE;
		else if (pick < 60)
			op = OP_QUERY;
		else if (pick < 80)
			op = OP_TICK;
		else if (pick < 90)
			op = OP_SWEEP;
		else if (pick < 94)
			op = OP_RESET_STATS;
		else
			op = OP_UNUSED;
		// mostly a few slots so entries get reused
		c = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 11)) : 6'($urandom_range(0, 63));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			to = 16'd0;
		else if (pick < 8)
			to = 16'($urandom_range(1, 4));
		else if (pick < 9)
			to = 16'($urandom_range(0, 65535));
		else
			to = 16'hFFFF;
		send_word(op, c, ($urandom_range(0, 9) < 7), to);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0 || !in_ready);
	endtask

	task automatic write_default(input logic [15:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] value;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_QUERY, 6'd0, 1'b0, 16'd0);
		send_word(OP_SWEEP, 6'd0, 1'b0, 16'd0);
		send_word(OP_REQ_START, 6'd0, 1'b1, 16'd0);
		send_word(OP_REQ_START, 6'd63, 1'b0, 16'hFFFF);
		send_word(OP_REQ_START, 6'd0, 1'b1, 16'd2);
		send_word(OP_REQ_START, 6'd5, 1'b1, 16'd1);
		send_word(OP_QUERY, 6'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 6'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 6'd63, 1'b1, 16'hFFFF);
		send_word(OP_REQ_COMPLETE, 6'd0, 1'b0, 16'd0);
		send_word(OP_REQ_COMPLETE, 6'd10, 1'b0, 16'd0);
		send_word(OP_UNUSED, 6'd63, 1'b1, 16'hFFFF);
		send_word(OP_SWEEP, 6'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 6'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 6'd0, 1'b0, 16'd0);
		send_word(OP_SWEEP, 6'd63, 1'b1, 16'hFFFF);
		send_word(OP_QUERY, 6'd5, 1'b0, 16'd0);
		send_word(OP_CLOSE, 6'd63, 1'b0, 16'd0);
		send_word(OP_CLOSE, 6'd63, 1'b0, 16'd0);
		send_word(OP_RESET_STATS, 6'd0, 1'b0, 16'd0);
		send_word(OP_QUERY, 6'd63, 1'b0, 16'd0);
		send_word(OP_REQ_START, 6'd42, 1'b1, 16'd0);
		send_word(OP_SWEEP, 6'd0, 1'b0, 16'd0);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: value = 16'd1;
				1: value = 16'hFFFF;
				2: value = 16'($urandom_range(2, 65534));
				3: value = 16'd2;
				default: value = 16'd5;
			endcase
			write_default(value);
			if (p == 4)
				idling = 1'b0;
			repeat (100) send_random_word();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("connection_idle_timeout_table_test: PASS");
		else
			$display("connection_idle_timeout_table_test: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("connection_idle_timeout_table_test: FAIL");
		$finish;
	end

endmodule
